// File: sv/websocket_frame_receiver_assert.svh
// Assertion macros for the WebSocket frame receiver.
// No dependencies; included by the top level, the only module that checks its own logic.
`ifndef WEBSOCKET_FRAME_RECEIVER_ASSERT_SVH
`define WEBSOCKET_FRAME_RECEIVER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication under a synchronous reset.
`define WSR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wsr assertion failed");
// Next-cycle implication under a synchronous reset.
`define WSR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wsr assertion failed");
`else
`define WSR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define WSR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: sv/wsr_pkg.sv
// Shared types, codes and helper functions of the WebSocket frame receiver.
// No dependencies; imported by the parser and the top level.
package wsr_pkg;

   // result kinds
   localparam logic [2:0] KIND_TEXT  = 3'd0;
   localparam logic [2:0] KIND_BIN   = 3'd1;
   localparam logic [2:0] KIND_PING  = 3'd2;
   localparam logic [2:0] KIND_CLOSE = 3'd3;
   localparam logic [2:0] KIND_PONG  = 3'd4;
   localparam logic [2:0] KIND_ERR   = 3'd5;

   // frame opcodes
   localparam logic [3:0] OP_CONT  = 4'h0;
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_BIN   = 4'h2;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;

   // open message type
   localparam logic [1:0] MSG_NONE = 2'd0;
   localparam logic [1:0] MSG_TEXT = 2'd1;
   localparam logic [1:0] MSG_BIN  = 2'd2;

   // second header byte length codes
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
      logic       block_last;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] payload_byte;
      logic       has_data;
      logic       frame_end;
      logic       message_end;
      logic       reply_close;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type item;
   } parse_out_type;

   function automatic logic [2:0] frame_kind(input logic [3:0] opcode,
                                             input logic [1:0] msg_type);
      logic [2:0] k;
      begin
         case (opcode)
            OP_CONT: begin
               if (msg_type == MSG_TEXT) k = KIND_TEXT;
               else if (msg_type == MSG_BIN) k = KIND_BIN;
               else k = KIND_ERR;
            end
            OP_TEXT:  k = KIND_TEXT;
            OP_BIN:   k = KIND_BIN;
            OP_CLOSE: k = KIND_CLOSE;
            OP_PING:  k = KIND_PING;
            OP_PONG:  k = KIND_PONG;
            default:  k = KIND_ERR;
         endcase
         return k;
      end
   endfunction

   function automatic logic kind_has_data(input logic [2:0] k);
      return (k == KIND_TEXT) || (k == KIND_BIN) || (k == KIND_PING) ||
             (k == KIND_CLOSE);
   endfunction

endpackage

// File: sv/wsr_stream_if.sv
// Valid/ready stream channel used for the request and response sides.
// No dependencies; the payload type is set by the instantiating module.
interface wsr_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: sv/wsr_parser.sv
// Frame parser state and per-beat decode of the WebSocket frame receiver.
// Depends on wsr_pkg for the item types, codes and kind helpers.
module wsr_parser
   import wsr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  req_type       item,
   output parse_out_type result
);

   localparam logic [2:0] PH_HDR0 = 3'd0;
   localparam logic [2:0] PH_HDR1 = 3'd1;
   localparam logic [2:0] PH_EXT  = 3'd2;
   localparam logic [2:0] PH_KEY  = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic [63:0] left_ff, left_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  idx_ff, idx_in;
   logic [1:0]  msg_ff, msg_in;
   logic        close_sent_ff, close_sent_in;
   logic        drop_ff, drop_in;

   logic        hd_now, hd_masked;
   logic [63:0] hd_len;
   logic        end_now, end_has;
   logic [7:0]  end_byte;
   logic [7:0]  key_byte, data_byte;
   logic [2:0]  kind_now;

   assign kind_now = frame_kind(opcode_ff, msg_ff);

   always_comb begin
      case (idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   assign data_byte = masked_ff ? (item.rx_byte ^ key_byte) : item.rx_byte;

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      fin_in        = fin_ff;
      opcode_in     = opcode_ff;
      masked_in     = masked_ff;
      left_in       = left_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      msg_in        = msg_ff;
      close_sent_in = close_sent_ff;
      drop_in       = drop_ff;
      hd_now        = 1'b0;
      hd_masked     = 1'b0;
      hd_len        = '0;
      end_now       = 1'b0;
      end_has       = 1'b0;
      end_byte      = '0;
      result        = '0;

      if (item.command) begin
         close_sent_in = 1'b1;
         msg_in        = MSG_NONE;
      end else if (drop_ff) begin
         // discard the rest of the receive block after a close
         if (item.block_last) drop_in = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_HDR0: begin
               fin_in    = item.rx_byte[7];
               opcode_in = item.rx_byte[3:0];
               phase_in  = PH_HDR1;
            end
            PH_HDR1: begin
               masked_in = item.rx_byte[7];
               if (item.rx_byte[6:0] == LEN_EXT16 || item.rx_byte[6:0] == LEN_EXT64) begin
                  count_in = (item.rx_byte[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
                  left_in  = '0;
                  phase_in = PH_EXT;
               end else begin
                  left_in   = {57'd0, item.rx_byte[6:0]};
                  hd_now    = 1'b1;
                  hd_masked = item.rx_byte[7];
                  hd_len    = {57'd0, item.rx_byte[6:0]};
               end
            end
            PH_EXT: begin
               left_in  = {left_ff[55:0], item.rx_byte};
               count_in = count_ff - 4'd1;
               if (count_ff == 4'd1) begin
                  hd_now    = 1'b1;
                  hd_masked = masked_ff;
                  hd_len    = {left_ff[55:0], item.rx_byte};
               end
            end
            PH_KEY: begin
               key_in   = {key_ff[23:0], item.rx_byte};
               count_in = count_ff - 4'd1;
               if (count_ff == 4'd1) begin
                  idx_in = 2'd0;
                  if (left_ff == 64'd0) end_now = 1'b1;
                  else phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               idx_in  = idx_ff + 2'd1;
               left_in = left_ff - 64'd1;
               if (left_ff == 64'd1) begin
                  end_now  = 1'b1;
                  end_has  = 1'b1;
                  end_byte = data_byte;
               end else if (kind_has_data(kind_now)) begin
                  result.valid             = 1'b1;
                  result.item.kind         = kind_now;
                  result.item.payload_byte = data_byte;
                  result.item.has_data     = 1'b1;
                  result.item.message_end  = fin_ff;
                  result.item.reply_close  = (kind_now == KIND_CLOSE) && !close_sent_ff;
               end
            end
            default: phase_in = PH_HDR0;
         endcase
      end

      // header complete: fetch the key, or go to payload, or end an empty frame
      if (hd_now) begin
         if (hd_masked) begin
            phase_in = PH_KEY;
            count_in = 4'd4;
         end else begin
            idx_in = 2'd0;
            if (hd_len == 64'd0) end_now = 1'b1;
            else phase_in = PH_DATA;
         end
      end

      if (end_now) begin
         phase_in = PH_HDR0;
         result.valid             = 1'b1;
         result.item.kind         = kind_now;
         result.item.has_data     = end_has && kind_has_data(kind_now);
         result.item.payload_byte = (end_has && kind_has_data(kind_now)) ? end_byte : 8'd0;
         result.item.frame_end    = 1'b1;
         result.item.message_end  = fin_ff;
         case (kind_now) inside
            KIND_TEXT, KIND_BIN: begin
               if (fin_ff) msg_in = MSG_NONE;
               else msg_in = (kind_now == KIND_TEXT) ? MSG_TEXT : MSG_BIN;
            end
            KIND_CLOSE: begin
               if (!close_sent_ff) begin
                  result.item.reply_close = 1'b1;
                  msg_in = MSG_NONE;
               end
               close_sent_in = 1'b1;
               if (!item.block_last) drop_in = 1'b1;
            end
            KIND_ERR: begin
               result.item.reply_close = 1'b1;
               close_sent_in = 1'b1;
               msg_in = MSG_NONE;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR0;
         count_ff      <= '0;
         fin_ff        <= 1'b0;
         opcode_ff     <= '0;
         masked_ff     <= 1'b0;
         left_ff       <= '0;
         key_ff        <= '0;
         idx_ff        <= '0;
         msg_ff        <= MSG_NONE;
         close_sent_ff <= 1'b0;
         drop_ff       <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         fin_ff        <= fin_in;
         opcode_ff     <= opcode_in;
         masked_ff     <= masked_in;
         left_ff       <= left_in;
         key_ff        <= key_in;
         idx_ff        <= idx_in;
         msg_ff        <= msg_in;
         close_sent_ff <= close_sent_in;
         drop_ff       <= drop_in;
      end
   end

endmodule

// File: sv/websocket_frame_receiver.sv
// WebSocket frame receiver: receive-side frame parser and payload unmasker.
// Channel req (sink) takes one beat per stream byte or a local close command:
//   command, rx_byte, block_last.
// Channel rsp (source) gives at most one result beat per request beat:
//   kind, payload_byte, has_data, frame_end, message_end, reply_close.
// Each request beat is held in an input register, decoded against the parser
// state and, if it makes a result, written to the result register.
// Throughput is one byte per clock while rsp does not stall; the 64-bit
// remaining-length decrement and compare in the payload phase sets the cycle
// time. Header bytes that do not end an empty frame, dropped bytes and close
// commands produce no result beat.
// A stalled rsp holds the result register; req then takes at most one more
// beat into the input register and holds ready low until the result is taken.
// Reset (synchronous) empties both registers and returns the parser to the
// first header byte with no open message and no close sent.
// Depends on wsr_pkg, wsr_stream_if, wsr_parser and the assertion macros.
`include "websocket_frame_receiver_assert.svh"
module websocket_frame_receiver
   import wsr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   wsr_stream_if.sink   req,
   wsr_stream_if.source rsp
);

   logic          in_valid_ff, in_valid_in;
   req_type       in_item_ff;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_item_ff;
   logic          advance;
   parse_out_type parsed;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready   = !in_valid_ff || advance;
   assign in_valid_in = req.valid ? 1'b1 : (in_valid_ff && !advance);
   assign out_valid_in = advance ? parsed.valid : (out_valid_ff && !rsp.ready);

   wsr_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (parsed)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= req.ready ? in_valid_in : in_valid_ff;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: load on the beat, hold otherwise
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) in_item_ff <= req.payload;
      if (advance && parsed.valid) out_item_ff <= parsed.item;
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_item_ff;

   `WSR_ASSERT_NEXT(a_in_held, clock, reset, in_valid_ff && !advance, in_valid_ff)
   `WSR_ASSERT_IMP(a_event_at_end, clock, reset,
      out_valid_ff && (out_item_ff.kind == KIND_PONG || out_item_ff.kind == KIND_ERR),
      out_item_ff.frame_end && !out_item_ff.has_data)
   `WSR_ASSERT_IMP(a_reply_kind, clock, reset,
      out_valid_ff && out_item_ff.reply_close,
      out_item_ff.kind == KIND_CLOSE || out_item_ff.kind == KIND_ERR)
   `WSR_ASSERT_IMP(a_mid_has_data, clock, reset,
      out_valid_ff && !out_item_ff.frame_end, out_item_ff.has_data)

endmodule

// File: tb/tb.sv
// Testbench for websocket_frame_receiver: feeds framed byte streams, noise and
// local close commands, predicts each result beat and checks it in order.
// Depends on wsr_pkg, wsr_stream_if and the websocket_frame_receiver top level.
import wsr_pkg::*;

typedef enum logic [2:0] {
   PH_HEAD0,
   PH_HEAD1,
   PH_EXT,
   PH_KEY,
   PH_DATA
} parse_phase_type;

typedef enum logic [1:0] {
   RDY_ALWAYS,
   RDY_COIN,
   RDY_PERIODIC,
   RDY_BURSTY
} stall_mode_type;

class frame_scoreboard_type;
   parse_phase_type phase;
   logic [3:0]   hdr_left;
   logic         fin;
   logic [3:0]   opcode;
   logic         masked;
   logic [63:0]  remaining;
   logic [31:0]  key;
   logic [1:0]   key_pos;
   logic [1:0]   open_msg;
   logic         close_done;
   logic         dropping;
   rsp_type      expected_rsp[$];
   int           errors;

   function new();
      phase = PH_HEAD0;
      hdr_left = '0;
      fin = 1'b0;
      opcode = '0;
      masked = 1'b0;
      remaining = '0;
      key = '0;
      key_pos = '0;
      open_msg = MSG_NONE;
      close_done = 1'b0;
      dropping = 1'b0;
      errors = 0;
   endfunction

   function logic [2:0] current_kind();
      case (opcode)
         OP_CONT: begin
            if (open_msg == MSG_TEXT) return KIND_TEXT;
            if (open_msg == MSG_BIN) return KIND_BIN;
            return KIND_ERR;
         end
         OP_TEXT:  return KIND_TEXT;
         OP_BIN:   return KIND_BIN;
         OP_CLOSE: return KIND_CLOSE;
         OP_PING:  return KIND_PING;
         OP_PONG:  return KIND_PONG;
         default:  return KIND_ERR;
      endcase
   endfunction

   function logic carries_data(logic [2:0] k);
      return k == KIND_TEXT || k == KIND_BIN || k == KIND_PING || k == KIND_CLOSE;
   endfunction

   function void push_result(logic [2:0] k, logic [7:0] d, logic has, logic fe, logic rc);
      rsp_type r;
      r.kind = k;
      r.payload_byte = has ? d : 8'h00;
      r.has_data = has;
      r.frame_end = fe;
      r.message_end = fin;
      r.reply_close = rc;
      expected_rsp.insert(expected_rsp.size(), r);
   endfunction

   function void finish_frame(logic [7:0] d, logic has, logic last);
      logic [2:0] k;
      logic       rc;
      k = current_kind();
      rc = 1'b0;
      phase = PH_HEAD0;
      if (!carries_data(k)) has = 1'b0;
      if (k == KIND_TEXT || k == KIND_BIN) begin
         open_msg = fin ? MSG_NONE : (k == KIND_TEXT ? MSG_TEXT : MSG_BIN);
      end else if (k == KIND_CLOSE) begin
         if (!close_done) begin
            rc = 1'b1;
            open_msg = MSG_NONE;
         end
         close_done = 1'b1;
         // skip what is left of this receive block
         if (!last) dropping = 1'b1;
      end else if (k == KIND_ERR) begin
         rc = 1'b1;
         close_done = 1'b1;
         open_msg = MSG_NONE;
      end
      push_result(k, d, has, 1'b1, rc);
   endfunction

   function void length_known(logic last);
      if (masked) begin
         phase = PH_KEY;
         hdr_left = 4'd4;
      end else begin
         key_pos = 2'd0;
         if (remaining == 64'd0) finish_frame(8'h00, 1'b0, last);
         else phase = PH_DATA;
      end
   endfunction

   function void note_rx_beat(req_type b);
      logic [6:0] len;
      logic [7:0] d;
      logic [2:0] k;
      if (b.command) begin
         close_done = 1'b1;
         open_msg = MSG_NONE;
         return;
      end
      if (dropping) begin
         if (b.block_last) dropping = 1'b0;
         return;
      end
      case (phase)
         PH_HEAD0: begin
            fin = b.rx_byte[7];
            opcode = b.rx_byte[3:0];
            phase = PH_HEAD1;
         end
         PH_HEAD1: begin
            len = b.rx_byte[6:0];
            masked = b.rx_byte[7];
            remaining = '0;
            if (len == LEN_EXT16 || len == LEN_EXT64) begin
               hdr_left = (len == LEN_EXT16) ? 4'd2 : 4'd8;
               phase = PH_EXT;
            end else begin
               remaining = 64'(len);
               length_known(b.block_last);
            end
         end
         PH_EXT: begin
            remaining = {remaining[55:0], b.rx_byte};
            hdr_left = hdr_left - 4'd1;
            if (hdr_left == 4'd0) length_known(b.block_last);
         end
         PH_KEY: begin
            key = {key[23:0], b.rx_byte};
            hdr_left = hdr_left - 4'd1;
            if (hdr_left == 4'd0) begin
               key_pos = 2'd0;
               if (remaining == 64'd0) finish_frame(8'h00, 1'b0, b.block_last);
               else phase = PH_DATA;
            end
         end
         PH_DATA: begin
            d = b.rx_byte;
            if (masked) d = d ^ key[8 * (3 - key_pos) +: 8];
            key_pos = key_pos + 2'd1;
            remaining = remaining - 64'd1;
            if (remaining == 64'd0) begin
               finish_frame(d, 1'b1, b.block_last);
            end else begin
               k = current_kind();
               if (carries_data(k))
                  push_result(k, d, 1'b1, 1'b0, k == KIND_CLOSE && !close_done);
            end
         end
         default: phase = PH_HEAD0;
      endcase
   endfunction

   task report(string what);
      if (errors < 40) $display("mismatch: %s", what);
      errors++;
   endtask

   task check_rsp_beat(rsp_type got);
      rsp_type want;
      if (expected_rsp.size() == 0) begin
         report($sformatf("result %h with nothing expected", got));
         return;
      end
      want = expected_rsp.pop_front();
      if (got.kind !== want.kind)
         report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.payload_byte !== want.payload_byte)
         report($sformatf("payload_byte %h, expected %h", got.payload_byte, want.payload_byte));
      if (got.has_data !== want.has_data)
         report($sformatf("has_data %b, expected %b", got.has_data, want.has_data));
      if (got.frame_end !== want.frame_end)
         report($sformatf("frame_end %b, expected %b", got.frame_end, want.frame_end));
      if (got.message_end !== want.message_end)
         report($sformatf("message_end %b, expected %b", got.message_end, want.message_end));
      if (got.reply_close !== want.reply_close)
         report($sformatf("reply_close %b, expected %b", got.reply_close, want.reply_close));
   endtask
endclass

module tb;
   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_BEATS = 1400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wsr_stream_if #(.payload_type(req_type)) req_if ();
   wsr_stream_if #(.payload_type(rsp_type)) rsp_if ();

   websocket_frame_receiver u_dut (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if)
   );

   frame_scoreboard_type sb;
   int             beats_sent = 0;
   int             burst_left = 0;
   int             idle_cycles = 0;
   stall_mode_type rsp_mode = RDY_ALWAYS;
   int             rsp_seg_left = 0;
   int             rsp_stall_left = 0;
   int             rsp_cycle = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic req_type byte_beat(logic [7:0] v, logic lst);
      req_type r;
      r.command = 1'b0;
      r.rx_byte = v;
      r.block_last = lst;
      return r;
   endfunction

   // keep extended lengths small so that noise cannot open a huge frame
   function automatic logic [7:0] noise_byte();
      logic [7:0] v;
      v = 8'($urandom);
      if (sb.phase == PH_EXT && sb.hdr_left > 4'd1) v = 8'h00;
      return v;
   endfunction

   task automatic send_beat(req_type b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.payload <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_rx_beat(b);
      beats_sent++;
   endtask

   task automatic send_local_close();
      req_type c;
      c.command = 1'b1;
      c.rx_byte = 8'($urandom);
      c.block_last = 1'($urandom_range(0, 1));
      send_beat(c);
   endtask

   // advance through any unfinished frame or dropped block
   task automatic resync();
      while (sb.phase != PH_HEAD0 || sb.dropping)
         send_beat(byte_beat(noise_byte(), $urandom_range(0, 3) == 0));
   endtask

   // form: 0 short length, 1 16-bit length, 2 64-bit length
   // end_last: block_last of the final byte, 2 for random
   // cmd_at: payload index before which a local close goes, -1 for none
   // cut: byte index at which the frame is abandoned, -1 for none
   task automatic send_frame(logic [3:0] op, logic fin, logic mask, int len, int form,
                             int end_last, int cmd_at, int cut);
      logic [7:0]  frame_bytes[$];
      logic [63:0] len64;
      logic [6:0]  code;
      logic        lst;
      int          hdr_n;
      int          i;
      resync();
      len64 = 64'(len);
      code = (form == 1) ? LEN_EXT16 : (form == 2) ? LEN_EXT64 : 7'(len);
      frame_bytes.insert(frame_bytes.size(), {fin, 3'($urandom), op});
      frame_bytes.insert(frame_bytes.size(), {mask, code});
      if (form == 1) begin
         frame_bytes.insert(frame_bytes.size(), len64[15:8]);
         frame_bytes.insert(frame_bytes.size(), len64[7:0]);
      end
      if (form == 2)
         for (i = 7; i >= 0; i--) frame_bytes.insert(frame_bytes.size(), len64[8 * i +: 8]);
      if (mask)
         repeat (4) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
      hdr_n = frame_bytes.size();
      repeat (len) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
      for (i = 0; i < frame_bytes.size(); i++) begin
         if (cut >= 0 && i == cut) break;
         if (cmd_at >= 0 && i == hdr_n + cmd_at) send_local_close();
         lst = ($urandom_range(0, 11) == 0);
         if (i == frame_bytes.size() - 1)
            lst = (end_last == 2) ? 1'($urandom_range(0, 1)) : 1'(end_last);
         send_beat(byte_beat(frame_bytes[i], lst));
      end
   endtask

   task automatic random_frame(int cut);
      logic [3:0] op;
      logic       fin;
      logic       mask;
      int         len;
      int         form;
      int         w;
      int         cmd_at;
      w = $urandom_range(0, 99);
      if (w < 20) op = OP_TEXT;
      else if (w < 35) op = OP_BIN;
      else if (w < 60) op = OP_CONT;
      else if (w < 70) op = OP_PING;
      else if (w < 78) op = OP_PONG;
      else if (w < 84) op = OP_CLOSE;
      else begin
         w = $urandom_range(0, 9);
         op = (w < 5) ? 4'(3 + w) : 4'(6 + w);
      end
      if (op == OP_TEXT || op == OP_BIN) fin = ($urandom_range(0, 2) == 0);
      else fin = 1'($urandom_range(0, 1));
      mask = ($urandom_range(0, 3) != 0);
      w = $urandom_range(0, 99);
      form = 0;
      if (w < 80) len = $urandom_range(0, 12);
      else if (w < 86) len = $urandom_range(13, 125);
      else if (w < 88) len = 125;
      else if (w < 96) begin
         form = 1;
         len = $urandom_range(0, 300);
      end else begin
         form = 2;
         len = $urandom_range(0, 300);
      end
      cmd_at = -1;
      if (len > 0 && $urandom_range(0, 29) == 0) cmd_at = $urandom_range(0, len - 1);
      send_frame(op, fin, mask, len, form, 2, cmd_at, cut);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check_rsp_beat(rsp_if.payload);
      if (rsp_seg_left == 0) begin
         rsp_mode = stall_mode_type'($urandom_range(0, 3));
         rsp_seg_left = $urandom_range(20, 200);
      end
      rsp_seg_left = rsp_seg_left - 1;
      rsp_cycle = rsp_cycle + 1;
      case (rsp_mode)
         RDY_ALWAYS:   rsp_if.ready <= 1'b1;
         RDY_COIN:     rsp_if.ready <= ($urandom_range(0, 1) == 1);
         RDY_PERIODIC: rsp_if.ready <= (rsp_cycle % 4 != 0);
         default: begin
            if (rsp_stall_left > 0) begin
               rsp_if.ready <= 1'b0;
               rsp_stall_left = rsp_stall_left - 1;
            end else begin
               rsp_if.ready <= 1'b1;
               if ($urandom_range(0, 7) == 0) rsp_stall_left = $urandom_range(1, 15);
            end
         end
      endcase
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int start;
      int sel;
      int n;
      sb = new();
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // complete text message, unmasked
      send_frame(OP_TEXT, 1'b1, 1'b0, 3, 0, 1, -1, -1);
      // fragmented binary message with a ping between fragments
      send_frame(OP_BIN, 1'b0, 1'b1, 4, 0, 0, -1, -1);
      send_frame(OP_CONT, 1'b0, 1'b1, 2, 0, 0, -1, -1);
      send_frame(OP_PING, 1'b1, 1'b1, 2, 0, 0, -1, -1);
      send_frame(OP_CONT, 1'b1, 1'b0, 1, 0, 1, -1, -1);
      // empty frames: short, masked, 16-bit and 64-bit lengths
      send_frame(OP_TEXT, 1'b1, 1'b0, 0, 0, 0, -1, -1);
      send_frame(OP_BIN, 1'b1, 1'b1, 0, 0, 1, -1, -1);
      send_frame(OP_PING, 1'b1, 1'b0, 0, 1, 0, -1, -1);
      send_frame(OP_TEXT, 1'b1, 1'b1, 0, 2, 0, -1, -1);
      // pongs are swallowed up to the frame end
      send_frame(OP_PONG, 1'b1, 1'b1, 3, 0, 0, -1, -1);
      send_frame(OP_PONG, 1'b0, 1'b0, 0, 0, 1, -1, -1);
      // extended lengths
      send_frame(OP_TEXT, 1'b1, 1'b1, 3, 1, 0, -1, -1);
      send_frame(OP_BIN, 1'b1, 1'b0, 2, 2, 0, -1, -1);
      // a new data frame replaces the open message
      send_frame(OP_TEXT, 1'b0, 1'b0, 1, 0, 0, -1, -1);
      send_frame(OP_BIN, 1'b1, 1'b1, 1, 0, 0, -1, -1);
      // first close wants a reply and drops the rest of its block
      send_frame(OP_CLOSE, 1'b1, 1'b1, 2, 0, 0, -1, -1);
      send_beat(byte_beat(8'h00, 1'b0));
      send_beat(byte_beat(8'hff, 1'b1));
      // second close ends on the block boundary: no reply, nothing dropped
      send_frame(OP_CLOSE, 1'b1, 1'b0, 2, 0, 1, -1, -1);
      // reserved opcodes and a continuation with no open message
      send_frame(4'h3, 1'b1, 1'b1, 2, 0, 0, -1, -1);
      send_frame(4'hF, 1'b1, 1'b0, 0, 0, 0, -1, -1);
      send_frame(OP_CONT, 1'b1, 1'b0, 1, 0, 0, -1, -1);
      // local close in the middle of a continuation frame
      send_frame(OP_TEXT, 1'b0, 1'b1, 1, 0, 0, -1, -1);
      send_frame(OP_CONT, 1'b1, 1'b1, 4, 0, 1, 2, -1);

      start = beats_sent;
      while (beats_sent - start < RANDOM_BEATS) begin
         sel = $urandom_range(0, 99);
         if (sel < 72) begin
            random_frame(-1);
         end else if (sel < 80) begin
            random_frame($urandom_range(0, 5));
         end else if (sel < 94) begin
            n = $urandom_range(1, 8);
            repeat (n) send_beat(byte_beat(noise_byte(), $urandom_range(0, 5) == 0));
         end else begin
            send_local_close();
         end
      end
      req_if.valid <= 1'b0;

      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
